// ===== rtl/simple_moving_average_defines.svh =====
// Assertion macros for the moving average port checker.
`ifndef SIMPLE_MOVING_AVERAGE_DEFINES_SVH
`define SIMPLE_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SMA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("moving average: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("moving average: next-cycle check failed");

`endif

// ===== rtl/sma_pkg.sv =====
// Shared widths, state codes and divider status for the moving average block.
package sma_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int SAMPLE_BITS = 32;
  localparam int SUM_BITS    = 40;
  localparam int WLEN_BITS   = 9;
  localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
  localparam int DCNT_BITS   = $clog2(SUM_BITS);

  localparam logic [WLEN_BITS-1:0] WLEN_RESET = WLEN_BITS'(20);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_SUB  = 7'b0000100,
    S_ADD  = 7'b0001000,
    S_ABS  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } sma_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sma_div_stat_t;

endpackage

// ===== rtl/sma_ifs.sv =====
// Channel interfaces: sample request, result request and window register write.
interface sma_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [sma_pkg::SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sma_result_if;
  logic                               valid;
  logic                               ready;
  logic                               valid_res;
  logic signed [sma_pkg::SAMPLE_BITS-1:0] average;
  modport source (output valid, output valid_res, output average, input ready);
  modport sink   (input valid, input valid_res, input average, output ready);
endinterface

interface sma_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sma_pkg::WLEN_BITS-1:0]    window_length;
  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

// ===== rtl/simple_moving_average.sv =====
// Simple moving average over the last N signed Q16.16 samples.
// Channels: in_ch takes one sample per request; out_ch returns one result per
// sample (valid_res, average); cfg_ch writes window_length (N, 9 bits).
// A window_length of 0 acts as 1 and values above 256 act as 256.
// A cfg write empties the window: sum, fill count and ring slot go to zero.
// Until N samples are held, results carry valid_res = 0 and average = 0.
// After that each result is the window sum divided by N, truncated toward 0.
// One sample at a time: in_ch.ready is high only when the block is idle.
// A sample passes through READ, SUB and ADD, then goes straight to OUT while
// the window fills, or through ABS and DIV to OUT once it is full. The next
// sample can be taken in the cycle after the result leaves, so any out_ch
// stall adds to the time per sample. The 40-step bit-serial divider runs in
// DIV; the ring is one 256 x 32 memory with a registered read port.
// The result is held on out_ch until taken; the block stays busy meanwhile.
// Reset (rst_n low, synchronous) empties the window and sets N to 20.
// Ring entries have no reset; an entry's value is used only after it was written.
module simple_moving_average (
  input logic      clk,
  input logic      rst_n,
  sma_sample_if.sink in_ch,
  sma_result_if.source out_ch,
  sma_cfg_if.sink  cfg_ch
);
  import sma_pkg::*;

  sma_state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SUM_BITS-1:0]    sum_r;
  logic [WLEN_BITS-1:0]          wlen_r;
  logic [WLEN_BITS-1:0]          fill_r;
  logic [SLOT_BITS-1:0]          slot_r;
  logic                          neg_r;
  logic                          valid_res_r;
  logic signed [SAMPLE_BITS-1:0] avg_r;

  logic [WLEN_BITS-1:0]          n_eff;
  logic                          full;
  logic [SLOT_BITS-1:0]          slot_use;
  logic [WLEN_BITS-1:0]          slot_inc;
  logic                          in_acc;
  logic                          cfg_acc;
  logic                          div_start;
  logic [SUM_BITS-1:0]           div_dividend;
  sma_div_stat_t                 div_stat;
  logic [SUM_BITS-1:0]           div_quo;
  logic [SAMPLE_BITS-1:0]        quo_lo;

  always_comb begin
    if (wlen_r == '0) begin
      n_eff = WLEN_BITS'(1);
    end else if (wlen_r > WLEN_BITS'(MAX_WINDOW)) begin
      n_eff = WLEN_BITS'(MAX_WINDOW);
    end else begin
      n_eff = wlen_r;
    end
  end

  assign full     = (fill_r >= n_eff);
  assign slot_use = ({1'b0, slot_r} >= n_eff) ? '0 : slot_r;
  assign slot_inc = {1'b0, slot_r} + 1'b1;

  // Config wins over a sample offered in the same cycle.
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign div_start    = (state_r == S_ABS);
  assign div_dividend = sum_r[SUM_BITS-1] ? SUM_BITS'(-sum_r) : SUM_BITS'(sum_r);
  assign quo_lo       = div_quo[SAMPLE_BITS-1:0];

  sma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_eff),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_READ;
      S_READ: state_nxt = S_SUB;
      S_SUB:  state_nxt = S_ADD;
      S_ADD:  state_nxt = full ? S_ABS : S_OUT;
      S_ABS:  state_nxt = S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_OUT;
      S_OUT:  if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wlen_r  <= WLEN_RESET;
      sum_r   <= '0;
      fill_r  <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        wlen_r <= cfg_ch.window_length;
        sum_r  <= '0;
        fill_r <= '0;
        slot_r <= '0;
      end else begin
        unique case (state_r)
          S_READ: slot_r <= slot_use;
          S_SUB: begin
            // Drop the oldest sample once the window is full.
            if (full) begin
              sum_r <= sum_r - SUM_BITS'(rd_data_r);
            end else begin
              fill_r <= fill_r + 1'b1;
            end
          end
          S_ADD: begin
            sum_r  <= sum_r + SUM_BITS'(sample_r);
            slot_r <= (slot_inc >= n_eff) ? '0 : slot_inc[SLOT_BITS-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // Ring memory: read in READ, overwrite the same slot in SUB.
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rd_data_r <= ring[slot_use];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SUB) begin
      ring[slot_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_ch.sample;
    end
    if (state_r == S_ABS) begin
      neg_r <= sum_r[SUM_BITS-1];
    end
    if (state_r == S_ADD && !full) begin
      valid_res_r <= 1'b0;
      avg_r       <= '0;
    end else if (state_r == S_DIV && div_stat.done) begin
      valid_res_r <= 1'b1;
      avg_r       <= neg_r ? -quo_lo : quo_lo;
    end
  end

  assign out_ch.valid     = (state_r == S_OUT);
  assign out_ch.valid_res = valid_res_r;
  assign out_ch.average   = avg_r;

endmodule

// ===== rtl/sma_div.sv =====
// Bit-serial restoring divider: unsigned sum magnitude by window length.
module sma_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sma_pkg::SUM_BITS-1:0]  dividend,
  input  logic [sma_pkg::WLEN_BITS-1:0] divisor,
  output sma_pkg::sma_div_stat_t        stat,
  output logic [sma_pkg::SUM_BITS-1:0]  quotient
);
  import sma_pkg::*;

  logic [SUM_BITS-1:0]  quo_r;
  logic [WLEN_BITS-1:0] rem_r;
  logic [WLEN_BITS-1:0] dvs_r;
  logic [DCNT_BITS-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [WLEN_BITS:0]   rem_sh;
  logic [WLEN_BITS:0]   rem_diff;
  logic                 take;

  // Remainder stays below the divisor, so it fits the divisor width.
  assign rem_sh   = {rem_r, quo_r[SUM_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign take     = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_BITS'(SUM_BITS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_BITS-2:0], take};
      rem_r <= take ? rem_diff[WLEN_BITS-1:0] : rem_sh[WLEN_BITS-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== rtl/sma_chk.sv =====
// Port-level checker for the moving average block, bound to the top level.
`include "simple_moving_average_defines.svh"

module sma_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 out_valid_res,
  input logic signed [sma_pkg::SAMPLE_BITS-1:0] out_average,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready
);

  // A taken sample keeps the block busy for at least the next cycle.
  `SMA_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  // No new sample or window write is taken while a result is pending.
  `SMA_ASSERT_NOW(a_one_in_flight, out_valid, !in_ready && !cfg_ready)
  // A filling window reports a zero average.
  `SMA_ASSERT_NOW(a_zero_when_filling, out_valid && !out_valid_res, out_average == '0)
  // A stalled result holds its payload.
  `SMA_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready,
                   out_valid && $stable(out_valid_res) && $stable(out_average))
  // A window write is never followed at once by a result.
  `SMA_ASSERT_NEXT(a_cfg_quiet, cfg_valid && cfg_ready, !out_valid)

endmodule

bind simple_moving_average sma_chk u_sma_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_valid_res (out_ch.valid_res),
  .out_average   (out_ch.average),
  .cfg_valid     (cfg_ch.valid),
  .cfg_ready     (cfg_ch.ready)
);

// ===== tb/sma_avg_checker.sv =====
// Checker for the moving average block: predicts each result and compares it.
module sma_avg_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic signed [sma_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic                                  out_valid_res,
  input  logic signed [sma_pkg::SAMPLE_BITS-1:0] out_average,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [sma_pkg::WLEN_BITS-1:0]          cfg_window_length,
  output int                                    fail_count,
  output int                                    pending_results
);

  typedef struct packed {
    logic                                  valid_res;
    logic signed [sma_pkg::SAMPLE_BITS-1:0] average;
  } avg_result_t;

  logic signed [sma_pkg::SAMPLE_BITS-1:0] ring [sma_pkg::MAX_WINDOW];
  logic signed [sma_pkg::SUM_BITS-1:0]    window_sum;
  logic [sma_pkg::WLEN_BITS-1:0]          wlen_reg;
  int                                     held;
  int                                     next_slot;
  avg_result_t                            expected_avgs [$];

  function automatic int window_len();
    int n;
    n = int'(wlen_reg);
    if (n == 0) n = 1;
    if (n > sma_pkg::MAX_WINDOW) n = sma_pkg::MAX_WINDOW;
    return n;
  endfunction

  // Advance the window by one sample and return the result it yields.
  function automatic avg_result_t predict_average(
    input logic signed [sma_pkg::SAMPLE_BITS-1:0] s
  );
    int          n;
    int          slot;
    longint      quot;
    avg_result_t r;
    n = window_len();
    slot = next_slot;
    if (slot >= n) slot = 0;
    if (held >= n) window_sum = window_sum - ring[slot];
    else held = held + 1;
    ring[slot] = s;
    window_sum = window_sum + s;
    slot = slot + 1;
    if (slot >= n) slot = 0;
    next_slot = slot;
    r = '0;
    if (held >= n) begin
      quot = longint'(window_sum) / longint'(n);
      r.valid_res = 1'b1;
      r.average = quot[sma_pkg::SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin
    avg_result_t exp_r;
    if (!rst_n) begin
      wlen_reg = sma_pkg::WLEN_RESET;
      window_sum = '0;
      held = 0;
      next_slot = 0;
      expected_avgs.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        // a register write empties the window
        wlen_reg = cfg_window_length;
        window_sum = '0;
        held = 0;
        next_slot = 0;
      end
      if (out_valid && out_ready) begin
        if (expected_avgs.size() == 0) begin
          $error("result with no sample request pending: valid_res %0d average %0d",
                 out_valid_res, out_average);
          fail_count = fail_count + 1;
        end else begin
          exp_r = expected_avgs.pop_front();
          if (out_valid_res !== exp_r.valid_res) begin
            $error("valid_res: expected %0d, actual %0d", exp_r.valid_res, out_valid_res);
            fail_count = fail_count + 1;
          end
          if (out_average !== exp_r.average) begin
            $error("average: expected %0d, actual %0d", exp_r.average, out_average);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) expected_avgs.push_back(predict_average(in_sample));
    end
    pending_results = expected_avgs.size();
  end

endmodule

// ===== tb/tb_simple_moving_average.sv =====
// Top of the moving average testbench: clock, reset, stimulus and verdict.
module tb_simple_moving_average;

  localparam logic signed [31:0] SAMPLE_HI = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAMPLE_LO = 32'sh8000_0000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_results;
  int   samples_sent;
  int   random_sent;
  int   results_taken;

  sma_sample_if in_if ();
  sma_result_if out_if ();
  sma_cfg_if    cfg_if ();

  simple_moving_average dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  sma_avg_checker avg_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_if.valid),
    .in_ready          (in_if.ready),
    .in_sample         (in_if.sample),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_valid_res     (out_if.valid_res),
    .out_average       (out_if.average),
    .cfg_valid         (cfg_if.valid),
    .cfg_ready         (cfg_if.ready),
    .cfg_window_length (cfg_if.window_length),
    .fail_count        (fail_count),
    .pending_results   (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic signed [31:0] draw_sample(input bit extremes);
    int unsigned pick;
    pick = $urandom_range(0, extremes ? 5 : 15);
    case (pick)
      0, 1:    return SAMPLE_HI;
      2, 3:    return SAMPLE_LO;
      4:       return 32'($urandom_range(0, 16)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  // Offer one sample request; return at the edge that accepts it.
  task automatic send_sample(input logic signed [31:0] s);
    int gap;
    gap = ((samples_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    samples_sent = samples_sent + 1;
  endtask

  // Drain all results, then write the window length.
  task automatic write_window(input logic [8:0] wlen);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    @(negedge clk);
    cfg_if.valid         <= 1'b1;
    cfg_if.window_length <= wlen;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input int count, input bit extremes);
    repeat (count) send_sample(draw_sample(extremes));
    random_sent = random_sent + count;
  endtask

  // Result side: random stalls, stretches with none, and two long holds to back up the input.
  initial begin
    int wait_cycles;
    results_taken = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (results_taken == 40 || results_taken == 450) wait_cycles = 300;
      else if ((results_taken / 70) % 4 == 1) wait_cycles = 0;
      else wait_cycles = $urandom_range(0, 10);
      if (wait_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      results_taken = results_taken + 1;
    end
  end

  initial begin
    logic [8:0] wlen;
    int         n;
    samples_sent = 0;
    random_sent = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.window_length = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // window of 20 from reset
    run_phase(30, 1'b0);

    // single-sample window passes samples through
    write_window(9'd1);
    send_sample(SAMPLE_HI);
    send_sample(SAMPLE_LO);
    send_sample(32'sd0);
    send_sample(-32'sd1);
    send_sample(32'sd1);

    // two-sample window: extremes and truncation toward zero
    write_window(9'd2);
    send_sample(SAMPLE_HI);
    send_sample(SAMPLE_HI);
    send_sample(SAMPLE_LO);
    send_sample(SAMPLE_LO);
    send_sample(-32'sd1);
    send_sample(-32'sd2);
    send_sample(32'sd3);

    // zero length acts as one
    write_window(9'd0);
    send_sample(32'sh8000_0001);
    send_sample(-32'sd7);
    send_sample(32'sh0001_8000);

    // full-size window, heavy on extremes for the sum range
    write_window(9'd256);
    run_phase(270, 1'b1);

    // above the maximum saturates
    write_window(9'd511);
    run_phase(262, 1'b0);

    while (random_sent < 600) begin
      case ($urandom_range(0, 9))
        0:       wlen = 9'd0;
        1:       wlen = 9'd1;
        2:       wlen = 9'd2;
        default: wlen = 9'($urandom_range(3, 48));
      endcase
      n = (wlen == 9'd0) ? 1 : int'(wlen);
      write_window(wlen);
      run_phase(n + $urandom_range(2, 30), 1'b0);
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== simple_moving_average.f =====
+incdir+rtl
rtl/sma_pkg.sv
rtl/sma_ifs.sv
rtl/sma_div.sv
rtl/simple_moving_average.sv
rtl/sma_chk.sv
tb/sma_avg_checker.sv
tb/tb_simple_moving_average.sv
